>>> sv/hwrs_pkg.sv
// ----------------------------------------------------------------------------
// hwrs_pkg
// Shared types, constants and codes of the health-weighted replica selector.
// ----------------------------------------------------------------------------
package hwrs_pkg;

  localparam int SERVERS   = 64;
  localparam int REPLICAS  = 4;
  localparam int TRIED_MAX = 4;
  localparam int ADDR_W    = $clog2(SERVERS);
  localparam int LANE_W    = $clog2(REPLICAS > 1 ? REPLICAS : 2);
  localparam int TOTAL_W   = 10;              // 4 * 255 fits
  localparam int RAND_W    = 31;
  localparam int HLTH_W    = 8;

  localparam logic [HLTH_W-1:0] HEALTH_RESET = 8'd50;
  localparam logic [HLTH_W-1:0] INC_RESET    = 8'd1;
  localparam logic [HLTH_W-1:0] MAX_RESET    = 8'd50;
  localparam logic [HLTH_W-1:0] MIN_RESET    = 8'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_STANDALONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INC_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEALTH_CAP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEALTH_FLOOR = 2'd3;

  typedef struct packed {
    logic [5:0]        cand_0;
    logic [5:0]        cand_1;
    logic [5:0]        cand_2;
    logic [5:0]        cand_3;
    logic [2:0]        cand_count;
    logic [7:0]        tried_0;
    logic [7:0]        tried_1;
    logic [7:0]        tried_2;
    logic [7:0]        tried_3;
    logic [2:0]        tried_count;
    logic [RAND_W-1:0] random_value;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [5:0] srv_id;
  } rsp_t;

  typedef logic [7:0]         tried_arr_t [TRIED_MAX];
  typedef logic [HLTH_W-1:0]  wgt_arr_t   [REPLICAS];
  typedef logic [TOTAL_W-1:0] sum_arr_t   [REPLICAS];

  // outcome of the merging stage
  typedef struct packed {
    logic              have;
    logic [LANE_W-1:0] idx;
  } sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_SUM,
    S_DIV,
    S_SEL,
    S_WR0,
    S_WR1,
    S_FIN
  } state_t;

endpackage

>>> sv/hwrs_if.sv
// ----------------------------------------------------------------------------
// hwrs_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface hwrs_req_if;
  import hwrs_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hwrs_rsp_if;
  import hwrs_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/health_weighted_replica_select.sv
// ----------------------------------------------------------------------------
// health_weighted_replica_select
// Picks one of up to four replica servers at random, weighted by per-server
// health, and keeps the health store up to date after each pick.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake            | beat
//   --------+-----+----------------------+-------------------------------------
//   req     | in  | req.valid/req.ready  | candidates, tried list, random value
//   rsp     | out | rsp.valid/rsp.ready  | found, srv_id
//   cfg     | in  | cfg_we               | cfg_idx selects register, cfg_wdata
//
// A weighted pick runs from one request beat to the next through health
// reads over the two read ports (S_RD0, S_RD1, S_RD2), a sum of the lanes,
// the remainder (four bits a cycle), a select, two health writes through
// the single write port, the hand-off of the result and a return to idle;
// the second write is skipped when there is no failed server in the store
// to halve. Standalone mode, or nothing left untried, goes straight to the
// hand-off; a zero weight total ends after the sum.
// Reset (rst, synchronous) marks all health entries as holding 50 at once;
// no clearing pass. req.ready stays low while rst is high. A stalled
// response sits in the output register while the next request is already
// taken and worked on.
// ----------------------------------------------------------------------------
module health_weighted_replica_select (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hwrs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [hwrs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  hwrs_req_if.sink                          req,
  hwrs_rsp_if.source                        rsp
);
  import hwrs_pkg::*;

  // configuration registers
  logic              standalone;
  logic [HLTH_W-1:0] inc_step;
  logic [HLTH_W-1:0] health_cap;
  logic [HLTH_W-1:0] health_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      standalone   <= 1'b0;
      inc_step     <= INC_RESET;
      health_cap   <= MAX_RESET;
      health_floor <= MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_STANDALONE:   standalone   <= cfg_wdata[0];
        CFG_INC_STEP:     inc_step     <= cfg_wdata;
        CFG_HEALTH_CAP:   health_cap   <= cfg_wdata;
        CFG_HEALTH_FLOOR: health_floor <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t state;
  state_t state_next;

  // latched request
  req_t       req_r;
  logic [2:0] nc_r;
  logic [2:0] nt_r;
  logic [5:0] cand_a  [REPLICAS];
  tried_arr_t tried_a;
  logic [7:0] last_tried;
  logic       fail_ok;

  // clamped counts of the incoming beat
  logic [2:0] nc_in;
  logic [2:0] nt_in;
  logic       accept;

  assign accept = req.valid && req.ready;
  assign nc_in  = (32'(req.data.cand_count) > REPLICAS) ? 3'(REPLICAS)
                                                         : req.data.cand_count;
  assign nt_in  = (32'(req.data.tried_count) > TRIED_MAX) ? 3'(TRIED_MAX)
                                                           : req.data.tried_count;

  always_comb begin
    logic [5:0] c4 [4];
    c4[0] = req_r.cand_0;
    c4[1] = req_r.cand_1;
    c4[2] = req_r.cand_2;
    c4[3] = req_r.cand_3;
    for (int i = 0; i < REPLICAS; i++) begin
      cand_a[i] = c4[i];
    end
    tried_a[0] = req_r.tried_0;
    tried_a[1] = req_r.tried_1;
    tried_a[2] = req_r.tried_2;
    tried_a[3] = req_r.tried_3;
    last_tried = tried_a[2'(nt_r - 3'd1)];
  end

  // the failed server is in the store and there was one
  assign fail_ok = (nt_r != 3'd0) && (32'(last_tried) < SERVERS);

  // health store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [HLTH_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_ra;
  logic [ADDR_W-1:0] ram_rb;
  logic [HLTH_W-1:0] ram_da;
  logic [HLTH_W-1:0] ram_db;

  hwrs_health_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_ra),
    .raddr_b (ram_rb),
    .rdata_a (ram_da),
    .rdata_b (ram_db)
  );

  // lane healths as read, failed server health
  logic [HLTH_W-1:0] h_r [REPLICAS];
  logic [HLTH_W-1:0] hf_r;

  // lanes
  wgt_arr_t weight_c;
  wgt_arr_t weight_r;

  for (genvar g = 0; g < REPLICAS; g++) begin : g_lane
    hwrs_lane u_lane (
      .cand   (cand_a[g]),
      .tried  (tried_a),
      .nt     (nt_r),
      .en     (32'(g) < 32'(nc_r)),
      .health (h_r[g]),
      .weight (weight_c[g])
    );
  end

  // merge
  sum_arr_t           wsum_c;
  sum_arr_t           wsum_r;
  logic [TOTAL_W-1:0] total_c;
  logic [TOTAL_W-1:0] pick;
  sel_t               sel;

  hwrs_merge u_merge (
    .weight   (weight_c),
    .wsum     (wsum_c),
    .total    (total_c),
    .weight_q (weight_r),
    .wsum_q   (wsum_r),
    .pick     (pick),
    .sel      (sel)
  );

  // remainder unit
  logic mod_start;
  logic mod_done;

  hwrs_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req_r.random_value),
    .divisor  (total_c),
    .done     (mod_done),
    .rem      (pick)
  );

  // health updates
  logic [LANE_W-1:0] ch_idx_r;
  logic [5:0]        ch_id;
  logic [HLTH_W:0]   inc_sum;
  logic [HLTH_W-1:0] ch_new;
  logic [HLTH_W-1:0] half;
  logic [HLTH_W-1:0] fail_new;

  assign ch_id    = cand_a[ch_idx_r];
  assign inc_sum  = {1'b0, h_r[ch_idx_r]} + {1'b0, inc_step};
  assign ch_new   = (inc_sum > {1'b0, health_cap}) ? health_cap : inc_sum[HLTH_W-1:0];
  assign half     = hf_r >> 1;
  assign fail_new = (half <= health_floor) ? health_floor : half;

  // result waiting for the output register
  logic       res_found;
  logic [5:0] res_id;
  logic       out_load;

  assign out_load = (state == S_FIN) && (!rsp.valid || rsp.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    ram_ra     = '0;
    ram_rb     = '0;
    ram_we     = 1'b0;
    ram_waddr  = ADDR_W'(ch_id);
    ram_wdata  = ch_new;
    mod_start  = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = !rst;
        if (req.valid) begin
          if (standalone || (nt_in >= nc_in)) begin
            state_next = S_FIN;
          end else begin
            state_next = S_RD0;
          end
        end
      end
      S_RD0: begin
        ram_ra     = ADDR_W'(cand_a[0]);
        ram_rb     = ADDR_W'(cand_a[1]);
        state_next = S_RD1;
      end
      S_RD1: begin
        ram_ra     = ADDR_W'(cand_a[2]);
        ram_rb     = ADDR_W'(cand_a[3]);
        state_next = S_RD2;
      end
      S_RD2: begin
        ram_ra     = ADDR_W'(last_tried);
        state_next = S_SUM;
      end
      S_SUM: begin
        if (total_c == '0) begin
          state_next = S_FIN;
        end else begin
          mod_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (mod_done) begin
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        state_next = sel.have ? S_WR0 : S_FIN;
      end
      S_WR0: begin
        ram_we     = 1'b1;
        state_next = fail_ok ? S_WR1 : S_FIN;
      end
      S_WR1: begin
        ram_we     = 1'b1;
        ram_waddr  = ADDR_W'(last_tried);
        ram_wdata  = fail_new;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          req_r     <= req.data;
          nc_r      <= nc_in;
          nt_r      <= nt_in;
          res_found <= standalone;
          res_id    <= '0;
        end
      end
      S_RD1: begin
        h_r[0] <= ram_da;
        h_r[1] <= ram_db;
      end
      S_RD2: begin
        h_r[2] <= ram_da;
        h_r[3] <= ram_db;
      end
      S_SUM: begin
        hf_r     <= ram_da;
        weight_r <= weight_c;
        wsum_r   <= wsum_c;
      end
      S_SEL: begin
        ch_idx_r <= sel.idx;
      end
      S_WR0: begin
        res_found <= 1'b1;
        res_id    <= ch_id;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.data.found  <= res_found;
      rsp.data.srv_id <= res_id;
    end
  end

endmodule

>>> sv/hwrs_health_ram.sv
// ----------------------------------------------------------------------------
// hwrs_health_ram
// Health store: one write port, two registered read ports, per-entry valid
// bits so that unwritten entries read as the reset health.
// ----------------------------------------------------------------------------
module hwrs_health_ram (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [hwrs_pkg::ADDR_W-1:0]   waddr,
  input  logic [hwrs_pkg::HLTH_W-1:0]   wdata,
  input  logic [hwrs_pkg::ADDR_W-1:0]   raddr_a,
  input  logic [hwrs_pkg::ADDR_W-1:0]   raddr_b,
  output logic [hwrs_pkg::HLTH_W-1:0]   rdata_a,
  output logic [hwrs_pkg::HLTH_W-1:0]   rdata_b
);
  import hwrs_pkg::*;

  logic [HLTH_W-1:0] mem [SERVERS];
  logic [SERVERS-1:0] vld;
  logic [HLTH_W-1:0] rd_a;
  logic [HLTH_W-1:0] rd_b;
  logic              vld_a;
  logic              vld_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      vld_a <= vld[raddr_a];
      vld_b <= vld[raddr_b];
    end
  end

  assign rdata_a = vld_a ? rd_a : HEALTH_RESET;
  assign rdata_b = vld_b ? rd_b : HEALTH_RESET;

endmodule

>>> sv/hwrs_lane.sv
// ----------------------------------------------------------------------------
// hwrs_lane
// One candidate lane: checks the tried list and yields the candidate weight.
// ----------------------------------------------------------------------------
module hwrs_lane (
  input  logic [5:0]                  cand,
  input  hwrs_pkg::tried_arr_t        tried,
  input  logic [2:0]                  nt,
  input  logic                        en,
  input  logic [hwrs_pkg::HLTH_W-1:0] health,
  output logic [hwrs_pkg::HLTH_W-1:0] weight
);
  import hwrs_pkg::*;

  logic seen;
  logic in_range;

  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < TRIED_MAX; j++) begin
      if ((32'(j) < 32'(nt)) && (tried[j] == {2'b00, cand})) begin
        seen = 1'b1;
      end
    end
  end

  assign in_range = 32'(cand) < SERVERS;
  assign weight   = (en && !seen && in_range) ? health : '0;

endmodule

>>> sv/hwrs_merge.sv
// ----------------------------------------------------------------------------
// hwrs_merge
// Merges the lanes: running weight sums, and the first lane with a nonzero
// weight whose sum exceeds the pick point.
// ----------------------------------------------------------------------------
module hwrs_merge (
  input  hwrs_pkg::wgt_arr_t           weight,
  output hwrs_pkg::sum_arr_t           wsum,
  output logic [hwrs_pkg::TOTAL_W-1:0] total,
  input  hwrs_pkg::wgt_arr_t           weight_q,
  input  hwrs_pkg::sum_arr_t           wsum_q,
  input  logic [hwrs_pkg::TOTAL_W-1:0] pick,
  output hwrs_pkg::sel_t               sel
);
  import hwrs_pkg::*;

  always_comb begin
    logic [TOTAL_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < REPLICAS; i++) begin
      acc     = acc + TOTAL_W'(weight[i]);
      wsum[i] = acc;
    end
    total = acc;
  end

  // lowest lane wins
  always_comb begin
    sel = '0;
    for (int i = REPLICAS - 1; i >= 0; i--) begin
      if ((weight_q[i] != '0) && (wsum_q[i] > pick)) begin
        sel.have = 1'b1;
        sel.idx  = LANE_W'(i);
      end
    end
  end

endmodule

>>> sv/hwrs_mod.sv
// ----------------------------------------------------------------------------
// hwrs_mod
// Iterative remainder of the random value by the weight total, four
// quotient bits a cycle.
// ----------------------------------------------------------------------------
module hwrs_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hwrs_pkg::RAND_W-1:0]   dividend,
  input  logic [hwrs_pkg::TOTAL_W-1:0]  divisor,
  output logic                          done,
  output logic [hwrs_pkg::TOTAL_W-1:0]  rem
);
  import hwrs_pkg::*;

  localparam int STEPS = 4;
  localparam int Q_W   = ((RAND_W + STEPS - 1) / STEPS) * STEPS;
  localparam int ITERS = Q_W / STEPS;
  localparam int CNT_W = $clog2(ITERS);

  logic [Q_W-1:0]     q;
  logic [TOTAL_W-1:0] d;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [TOTAL_W-1:0] rem_next;
  logic [Q_W-1:0]     q_next;

  always_comb begin
    logic [TOTAL_W:0] r2;
    rem_next = rem;
    q_next   = q;
    for (int k = 0; k < STEPS; k++) begin
      r2 = {rem_next, q_next[Q_W-1]};
      if (r2 >= {1'b0, d}) begin
        r2 = r2 - {1'b0, d};
      end
      rem_next = r2[TOTAL_W-1:0];
      q_next   = {q_next[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(ITERS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= Q_W'(dividend);
      d   <= divisor;
      rem <= '0;
    end else if (busy) begin
      q   <= q_next;
      rem <= rem_next;
    end
  end

  assign done = busy && (cnt == CNT_W'(ITERS - 1));

endmodule

>>> sv/hwrs_checker.sv
// ----------------------------------------------------------------------------
// hwrs_checker
// Port-level checks of the replica selector, bound to the top level.
// ----------------------------------------------------------------------------
module hwrs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [hwrs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input logic [hwrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input hwrs_pkg::rsp_t                  rsp_data
);
  import hwrs_pkg::*;

  logic       sa;
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa      <= 1'b0;
      pending <= '0;
    end else begin
      if (cfg_we && (cfg_idx == CFG_STANDALONE)) begin
        sa <= cfg_wdata[0];
      end
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response dropped or changed while stalled");

  a_standalone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && sa |-> rsp_data.found && (rsp_data.srv_id == '0))
    else $error("standalone mode answered other than server 0");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pending != 2'd0))
    else $error("response without a request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    (pending == 2'd2) |-> !req_ready)
    else $error("request taken with two results outstanding");

endmodule

bind health_weighted_replica_select hwrs_checker u_hwrs_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx),
  .cfg_wdata (cfg_wdata),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

>>> dv/tb_health_weighted_replica_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_health_weighted_replica_select
// Self-checking bench for the health-weighted replica selector. Requests go
// in through a valid/ready channel and are mirrored into a health-store
// predictor. Every response beat is compared field by field with the oldest
// predicted pick. The run steps through several register settings, the
// extremes among them, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_health_weighted_replica_select;
  import hwrs_pkg::*;

  localparam int QUIET_LIMIT  = 4000;  // cycles with no beat before giving up
  localparam int HOLD_CYCLES  = 300;   // long response hold-off
  localparam int END_SETTLE   = 40;    // idle wait after draining, before the final check

  // --------------------------------------------------------------------------
  // Health-store mirror and expected picks
  // --------------------------------------------------------------------------
  class replica_pick_checker;
    logic [HLTH_W-1:0] health [SERVERS];
    logic              standalone;
    logic [7:0]        inc_w;
    logic [7:0]        max_w;
    logic [7:0]        min_w;
    rsp_t              pending_picks [$];
    int                n_checked;
    int                n_err;
    int                n_picked;
    int                n_empty;
    int                n_alone;
    int                n_far_fail;

    function new();
      foreach (health[i]) health[i] = HEALTH_RESET;
      standalone = 1'b0;
      inc_w      = INC_RESET;
      max_w      = MAX_RESET;
      min_w      = MIN_RESET;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_STANDALONE:   standalone = val[0];
        CFG_INC_STEP:     inc_w      = val;
        CFG_HEALTH_CAP:   max_w      = val;
        CFG_HEALTH_FLOOR: min_w      = val;
        default: ;
      endcase
    endfunction

    // works out the pick for one accepted request and updates the store
    function void note_request(input req_t r);
      logic [5:0]        cand    [REPLICAS];
      logic [7:0]        tried   [TRIED_MAX];
      logic [HLTH_W-1:0] wgt     [REPLICAS];
      logic [TOTAL_W-1:0] run_sum [REPLICAS];
      bit                usable  [REPLICAS];
      int unsigned       nc, nt, pick, fail_id;
      logic [TOTAL_W-1:0] total;
      logic [8:0]        h;
      rsp_t              want;
      bit                hit;
      cand  = '{r.cand_0, r.cand_1, r.cand_2, r.cand_3};
      tried = '{r.tried_0, r.tried_1, r.tried_2, r.tried_3};
      want  = '0;
      nc = (r.cand_count > REPLICAS) ? REPLICAS : r.cand_count;
      nt = (r.tried_count > TRIED_MAX) ? TRIED_MAX : r.tried_count;
      if (standalone) begin
        want.found = 1'b1;
        n_alone++;
      end else if (nt < nc) begin
        total = '0;
        for (int i = 0; i < REPLICAS; i++) begin
          usable[i] = (i < nc);
          for (int j = 0; j < nt; j++)
            if (tried[j] == {2'b00, cand[i]}) usable[i] = 1'b0;
          wgt[i] = (int'(cand[i]) < SERVERS) ? health[cand[i]] : '0;
          if (usable[i]) total += wgt[i];
          run_sum[i] = total;
        end
        if (total != 0) begin
          pick = r.random_value % total;
          hit  = 1'b0;
          for (int i = 0; i < REPLICAS; i++) begin
            if (!hit && usable[i] && wgt[i] != 0 && run_sum[i] > pick) begin
              hit         = 1'b1;
              want.srv_id = cand[i];
            end
          end
          if (hit) begin
            want.found = 1'b1;
            h = {1'b0, health[want.srv_id]} + {1'b0, inc_w};
            if (h > {1'b0, max_w}) h = {1'b0, max_w};
            health[want.srv_id] = h[7:0];
            // the last tried id is the one that failed
            if (nt > 0) begin
              fail_id = tried[nt-1];
              if (fail_id < SERVERS) begin
                h = {2'b00, health[fail_id][7:1]};
                if (h <= {1'b0, min_w}) h = {1'b0, min_w};
                health[fail_id] = h[7:0];
              end else begin
                n_far_fail++;
              end
            end
            n_picked++;
          end
        end
      end
      if (!want.found) n_empty++;
      pending_picks.push_back(want);
    endfunction

    task report_mismatch(input string msg);
      n_err++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_response(input rsp_t got);
      rsp_t want;
      if (pending_picks.size() == 0) begin
        report_mismatch($sformatf("response found=%0d id=%0d with nothing outstanding",
                                  got.found, got.srv_id));
        return;
      end
      want = pending_picks.pop_front();
      if (got.found !== want.found)
        report_mismatch($sformatf("pick %0d: found %0d, expected %0d",
                                  n_checked, got.found, want.found));
      if (got.srv_id !== want.srv_id)
        report_mismatch($sformatf("pick %0d: id %0d, expected %0d",
                                  n_checked, got.srv_id, want.srv_id));
      n_checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hwrs_req_if req_ch ();
  hwrs_rsp_if rsp_ch ();

  health_weighted_replica_select u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  replica_pick_checker board = new();

  int n_sent;          // request beats accepted so far
  int n_settings;      // register settings applied
  int n_holds;         // long response hold-offs done
  int send_idle_pct;   // chance of a gap before each request beat
  int take_idle_pct;   // chance per cycle that the receiver stalls
  bit hold_asked;      // main asks the receiver for one long hold-off
  int hold_left;
  int quiet_cycles;

  // --------------------------------------------------------------------------
  // Beat monitor: both channels sampled at the edge, before any update lands
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) board.note_request(req_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.data);
    end
  end

  // Watchdog: any beat on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d picks outstanding",
                 quiet_cycles, board.pending_picks.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side: random stalls, plus one long hold-off on request so the
  // block fills up behind its output register and stops taking requests.
  // --------------------------------------------------------------------------
  initial begin
    rsp_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_asked) begin
        hold_asked = 1'b0;
        hold_left  = HOLD_CYCLES;
        n_holds++;
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request generation
  // --------------------------------------------------------------------------
  function automatic req_t compose_req(input int c0, c1, c2, c3, cc,
                                       input int t0, t1, t2, t3, tc,
                                       input logic [RAND_W-1:0] rv);
    req_t r;
    r.cand_0       = 6'(c0);
    r.cand_1       = 6'(c1);
    r.cand_2       = 6'(c2);
    r.cand_3       = 6'(c3);
    r.cand_count   = 3'(cc);
    r.tried_0      = 8'(t0);
    r.tried_1      = 8'(t1);
    r.tried_2      = 8'(t2);
    r.tried_3      = 8'(t3);
    r.tried_count  = 3'(tc);
    r.random_value = rv;
    return r;
  endfunction

  // Well-formed requests draw candidates mostly from a small pool so that
  // health moves and duplicates occur, and take tried ids mostly from the
  // candidates so exclusion bites. Noise leaves the counts and tried ids free.
  function automatic req_t make_request(input bit noisy);
    req_t        r;
    logic [31:0] rv;
    logic [5:0]  c [REPLICAS];
    int          pool_hi;
    rv      = $urandom();
    pool_hi = ($urandom_range(3) == 0) ? 63 : 7;
    foreach (c[i]) c[i] = 6'($urandom_range(pool_hi));
    r.cand_0       = c[0];
    r.cand_1       = c[1];
    r.cand_2       = c[2];
    r.cand_3       = c[3];
    r.random_value = rv[RAND_W-1:0];
    if (noisy) begin
      r.cand_count  = 3'($urandom_range(7));
      r.tried_count = 3'($urandom_range(7));
      r.tried_0     = 8'($urandom_range(255));
      r.tried_1     = 8'($urandom_range(255));
      r.tried_2     = 8'($urandom_range(255));
      r.tried_3     = 8'($urandom_range(255));
    end else begin
      r.cand_count  = 3'($urandom_range(1, REPLICAS));
      r.tried_count = ($urandom_range(9) == 0) ? r.cand_count
                                               : 3'($urandom_range(0, r.cand_count - 1));
      r.tried_0 = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                           : {2'b00, c[$urandom_range(REPLICAS-1)]};
      r.tried_1 = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                           : {2'b00, c[$urandom_range(REPLICAS-1)]};
      r.tried_2 = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                           : {2'b00, c[$urandom_range(REPLICAS-1)]};
      r.tried_3 = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                           : {2'b00, c[$urandom_range(REPLICAS-1)]};
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offers one request beat and returns at the edge it is taken. Valid stays
  // high so a back-to-back beat needs no second update in the same step.
  task automatic send_req(input req_t beat);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 24) : 0;
    repeat (gap) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= make_request(1'b1);  // junk while idle
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= beat;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) send_req(make_request($urandom_range(99) < 15));
  endtask

  // Sender goes quiet until every accepted request has been answered
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (board.n_checked != n_sent) @(posedge clk);
  endtask

  // One register per beat, all four each time; only while the block is idle
  task automatic set_config(input logic alone, input logic [7:0] inc_v, max_v, min_v);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  idxs [4];
    vals = '{{7'd0, alone}, inc_v, max_v, min_v};
    idxs = '{CFG_STANDALONE, CFG_INC_STEP, CFG_HEALTH_CAP, CFG_HEALTH_FLOOR};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idxs[i];
      cfg_wdata <= vals[i];
      board.set_reg(idxs[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_STANDALONE;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    hold_asked    = 1'b0;
    send_idle_pct = 35;
    take_idle_pct = 35;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values, written explicitly
    set_config(1'b0, INC_RESET, MAX_RESET, MIN_RESET);

    // field extremes and the corner cases
    send_req(compose_req(0, 0, 0, 0, 1,  0, 0, 0, 0, 0,  31'd0));
    send_req(compose_req(63, 63, 63, 63, 4,  0, 0, 0, 0, 0,  31'h7FFF_FFFF));
    // no candidates at all
    send_req(compose_req(1, 2, 3, 4, 0,  0, 0, 0, 0, 0,  31'd5));
    // both counts above range, clamped: nothing left untried
    send_req(compose_req(1, 2, 3, 4, 7,  100, 101, 102, 103, 7,  31'd9));
    send_req(compose_req(20, 21, 22, 23, 6,  1, 2, 3, 4, 5,  31'd9));
    send_req(compose_req(5, 6, 0, 0, 2,  5, 6, 0, 0, 2,  31'd1));
    // every candidate a copy of the tried one: zero total weight
    send_req(compose_req(7, 7, 7, 0, 3,  7, 0, 0, 0, 1,  31'd3));
    // failed ids beyond the store leave health alone
    send_req(compose_req(1, 2, 0, 0, 2,  200, 0, 0, 0, 1,  31'd77));
    send_req(compose_req(6'h2A, 6'h15, 3, 4, 4,  8'hAA, 8'h55, 8'hFF, 0, 3,  31'h5555_5555));
    // the same server failing again and again keeps halving toward the floor
    send_req(compose_req(8, 9, 10, 11, 4,  11, 0, 0, 0, 1,  31'd40));
    send_req(compose_req(8, 9, 10, 11, 4,  11, 0, 0, 0, 1,  31'd41));
    send_req(compose_req(8, 9, 10, 11, 4,  11, 0, 0, 0, 1,  31'd42));
    // duplicate candidates weigh in once per copy
    send_req(compose_req(12, 12, 13, 12, 4,  0, 0, 0, 0, 0,  31'd60));
    send_req(compose_req(20, 21, 22, 23, 5,  0, 0, 0, 0, 0,  31'h2AAA_AAAA));
    send_req(compose_req(30, 31, 32, 33, 4,  30, 31, 32, 0, 3,  31'd1234));
    send_req(compose_req(40, 41, 42, 43, 4,  40, 41, 42, 43, 4,  31'd8));
    run_random(270);

    // standalone answers server 0 whatever comes in
    wait_drained();
    set_config(1'b1, 8'd255, 8'd255, 8'd1);
    send_req(compose_req(17, 18, 19, 20, 0,  17, 0, 0, 0, 4,  31'd0));
    run_random(60);

    // widest weights, long stretch without a single idle cycle
    wait_drained();
    set_config(1'b0, 8'd255, 8'd255, 8'd1);
    send_idle_pct = 0;
    take_idle_pct = 0;
    run_random(150);
    send_idle_pct = 35;
    take_idle_pct = 35;

    // floor above the ceiling, no increment
    wait_drained();
    set_config(1'b0, 8'd0, 8'd1, 8'd255);
    run_random(100);

    // ceiling of zero: a picked server drops to zero weight
    wait_drained();
    set_config(1'b0, 8'd3, 8'd0, 8'd1);
    send_req(compose_req(9, 10, 0, 0, 2,  0, 0, 0, 0, 0,  31'd0));
    send_req(compose_req(9, 10, 0, 0, 2,  0, 0, 0, 0, 0,  31'd0));
    send_req(compose_req(9, 10, 9, 10, 4,  0, 0, 0, 0, 0,  31'd0));
    send_req(compose_req(9, 11, 0, 0, 2,  0, 0, 0, 0, 1,  31'd0));
    run_random(70);

    // floor of zero; long response hold-off while requests keep coming,
    // then one pause until everything is answered
    wait_drained();
    set_config(1'b0, 8'd7, 8'd100, 8'd0);
    run_random(80);
    hold_asked = 1'b1;
    run_random(60);
    wait_drained();
    run_random(60);

    // back to the reset values
    wait_drained();
    set_config(1'b0, INC_RESET, MAX_RESET, MIN_RESET);
    run_random(80);

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (board.pending_picks.size() != 0)
      board.report_mismatch($sformatf("%0d picks never answered",
                                      board.pending_picks.size()));

    $display("covered %0d requests over %0d settings: %0d weighted picks, %0d none, %0d standalone",
             n_sent, n_settings, board.n_picked, board.n_empty, board.n_alone);
    $display("%0d failed ids beyond the store, %0d long hold-offs, %0d mismatches",
             board.n_far_fail, n_holds, board.n_err);
    if (board.n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
